@@ rtl/mtwq_pkg.sv @@
package mtwq_pkg;

  localparam int MUTEX_COUNT_DEF = 32;
  localparam int TASK_COUNT_DEF  = 64;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int TASK_W   = 6;
  localparam int STATUS_W = 3;
  localparam int NEWM_W   = 5;
  localparam int HELD_W   = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_LOCK    = 2'd1,
    CMD_UNLOCK  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_INVALID   = 3'd2,
    ST_DEADLOCK  = 3'd3,
    ST_NOT_OWNER = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WAKE,
    S_OUT
  } state_t;

endpackage

@@ rtl/mtwq_if.sv @@
interface mtwq_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtwq_pkg::CMD_W-1:0]  command;
  logic [mtwq_pkg::ID_W-1:0]   mutex_id;
  logic [mtwq_pkg::TASK_W-1:0] task_id;
  modport source (output valid, command, mutex_id, task_id, input ready);
  modport sink (input valid, command, mutex_id, task_id, output ready);
endinterface

interface mtwq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mtwq_pkg::STATUS_W-1:0] status;
  logic [mtwq_pkg::NEWM_W-1:0]   new_mutex;
  logic                          must_sleep;
  logic                          wake_valid;
  logic [mtwq_pkg::TASK_W-1:0]   wake_task;
  logic [mtwq_pkg::HELD_W-1:0]   caller_held;
  modport source (output valid, status, new_mutex, must_sleep, wake_valid, wake_task,
                  caller_held, input ready);
  modport sink (input valid, status, new_mutex, must_sleep, wake_valid, wake_task,
                caller_held, output ready);
endinterface

@@ rtl/mtwq_ram.sv @@
module mtwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mutex_table_with_wait_queues_unit.sv @@
// From input acceptance to the result: link and caller count read, table update in
// S_READ, woken task count update in S_WAKE; S_OUT holds the result through result-side stalls.
// A new command is taken only when idle, so only one transaction is in flight.
// Reset: synchronous active-low rst_n clears the mutex table and the per-task count
// valid bits at once; the next-waiter and count memories themselves are not cleared.
module mutex_table_with_wait_queues_unit #(
  parameter int MUTEX_COUNT = mtwq_pkg::MUTEX_COUNT_DEF,
  parameter int TASK_COUNT  = mtwq_pkg::TASK_COUNT_DEF
) (
  input logic      clk,
  input logic      rst_n,
  mtwq_in_if.sink  in_ch,
  mtwq_out_if.source out_ch
);

  localparam int TW  = mtwq_pkg::TASK_W;
  localparam int HW  = mtwq_pkg::HELD_W;
  localparam int MW  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam int TIW = $clog2(TASK_COUNT);
  localparam logic [HW-1:0] HELD_MAX = '1;

  // Flip-flop mutex table: reset clears it at once, release-all its owners and queues.
  // The free search scans every allocation bit; other fields are read at the addressed entry.
  logic [MUTEX_COUNT-1:0] alloc_r, own_v_r, q_ne_r;
  logic [TW-1:0]          own_t_r [MUTEX_COUNT];
  logic [TW-1:0]          q_head_r [MUTEX_COUNT];
  logic [TW-1:0]          q_tail_r [MUTEX_COUNT];

  // Held counts live in a memory. A count whose valid bit is clear reads as zero,
  // which is how reset and release-all clear every count at once.
  logic [TASK_COUNT-1:0]  held_vld_r;

  mtwq_pkg::state_t state_r, state_nxt;
  logic [mtwq_pkg::CMD_W-1:0]  cmd_r;
  logic [mtwq_pkg::ID_W-1:0]   mid_r;
  logic [TW-1:0]               tid_r;

  // Output registers.
  logic [mtwq_pkg::STATUS_W-1:0] status_r;
  logic [mtwq_pkg::NEWM_W-1:0]   newm_r;
  logic                          sleep_r, wv_r;
  logic [TW-1:0]                 wt_r;
  logic [HW-1:0]                 held_out_r;

  // Next-waiter links in a synchronous memory; written on enqueue, read on handoff.
  logic           nw_we;
  logic [TIW-1:0] nw_waddr, nw_raddr;
  logic [TW-1:0]  nw_wdata, nw_rdata;

  // Held-count memory port signals.
  logic           held_we;
  logic [TIW-1:0] held_waddr, held_raddr;
  logic [HW-1:0]  held_wdata, held_rdata;

  mtwq_ram #(.WIDTH(TW), .DEPTH(TASK_COUNT)) u_next_waiter (
    .clk   (clk),
    .we    (nw_we),
    .waddr (nw_waddr),
    .wdata (nw_wdata),
    .raddr (nw_raddr),
    .rdata (nw_rdata)
  );

  mtwq_ram #(.WIDTH(HW), .DEPTH(TASK_COUNT)) u_held (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_waddr),
    .wdata (held_wdata),
    .raddr (held_raddr),
    .rdata (held_rdata)
  );

  logic accept;
  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == mtwq_pkg::S_IDLE);
  assign out_ch.valid = (state_r == mtwq_pkg::S_OUT);
  assign out_ch.status      = status_r;
  assign out_ch.new_mutex   = newm_r;
  assign out_ch.must_sleep  = sleep_r;
  assign out_ch.wake_valid  = wv_r;
  assign out_ch.wake_task   = wt_r;
  assign out_ch.caller_held = held_out_r;

  // Address the head of the addressed mutex's queue at acceptance time. Only one
  // transaction is in flight, so the tables cannot change before the data is used.
  logic          m_in_ok;
  logic [MW-1:0] m_in_idx;
  assign m_in_ok  = 32'(in_ch.mutex_id) < MUTEX_COUNT;
  assign m_in_idx = m_in_ok ? in_ch.mutex_id[MW-1:0] : '0;
  assign nw_raddr = q_head_r[m_in_idx][TIW-1:0];

  // Decode of the held transaction.
  logic           m_ok, t_ok;
  logic [MW-1:0]  mi;
  logic [TIW-1:0] ti;
  assign m_ok = 32'(mid_r) < MUTEX_COUNT;
  assign t_ok = 32'(tid_r) < TASK_COUNT;
  assign mi   = m_ok ? mid_r[MW-1:0] : '0;
  assign ti   = tid_r[TIW-1:0];

  // Lowest free mutex search.
  logic          found;
  logic [MW-1:0] free_idx;
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = MUTEX_COUNT - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        found    = 1'b1;
        free_idx = MW'(i);
      end
    end
  end

  // Compute step: decide outputs and table updates.
  logic [mtwq_pkg::STATUS_W-1:0] st_c;
  logic sleep_c, wv_c;
  logic [TW-1:0] wt_c;
  logic do_create, do_release, do_grant, do_enq, do_unlock, do_handoff;
  logic [TW-1:0] w_c;
  always_comb begin
    st_c       = mtwq_pkg::ST_OK;
    sleep_c    = 1'b0;
    wv_c       = 1'b0;
    wt_c       = '0;
    do_create  = 1'b0;
    do_release = 1'b0;
    do_grant   = 1'b0;
    do_enq     = 1'b0;
    do_unlock  = 1'b0;
    do_handoff = 1'b0;
    w_c        = q_head_r[mi];
    case (mtwq_pkg::cmd_t'(cmd_r))
      mtwq_pkg::CMD_CREATE: begin
        if (found) begin
          do_create = 1'b1;
        end else begin
          st_c = mtwq_pkg::ST_NO_FREE;
        end
      end
      mtwq_pkg::CMD_RELEASE: do_release = 1'b1;
      mtwq_pkg::CMD_LOCK: begin
        if (!m_ok || !alloc_r[mi] || !t_ok) begin
          st_c = mtwq_pkg::ST_INVALID;
        end else if (own_v_r[mi] && own_t_r[mi] == tid_r) begin
          st_c = mtwq_pkg::ST_DEADLOCK;
        end else if (own_v_r[mi]) begin
          do_enq  = 1'b1;
          sleep_c = 1'b1;
        end else begin
          do_grant = 1'b1;
        end
      end
      mtwq_pkg::CMD_UNLOCK: begin
        if (!m_ok || !alloc_r[mi] || !t_ok) begin
          st_c = mtwq_pkg::ST_INVALID;
        end else if (!own_v_r[mi] || own_t_r[mi] != tid_r) begin
          st_c = mtwq_pkg::ST_NOT_OWNER;
        end else begin
          do_unlock = 1'b1;
          if (q_ne_r[mi]) begin
            do_handoff = 1'b1;
            wv_c       = 1'b1;
            wt_c       = w_c;
          end
        end
      end
      default: st_c = mtwq_pkg::ST_OK;
    endcase
  end

  // Caller's count after the step. A task queued twice on a mutex can be handed
  // that mutex by its own unlock, so the handoff increment may land on the caller.
  logic [HW-1:0] held_caller_base, held_caller;
  assign held_caller_base = held_vld_r[ti] ? held_rdata : '0;
  always_comb begin
    held_caller = held_caller_base;
    if (do_grant && held_caller != HELD_MAX) begin
      held_caller = held_caller + 1'b1;
    end
    if (do_unlock && held_caller != '0) begin
      held_caller = held_caller - 1'b1;
    end
    if (do_handoff && w_c == tid_r && held_caller != HELD_MAX) begin
      held_caller = held_caller + 1'b1;
    end
  end

  // Woken task's count, read in the compute cycle (S_READ) and written back in S_WAKE.
  logic [HW-1:0] held_waiter_base, held_waiter_inc;
  assign held_waiter_base = held_vld_r[wt_r[TIW-1:0]] ? held_rdata : '0;
  assign held_waiter_inc  = (held_waiter_base != HELD_MAX) ?
                            held_waiter_base + 1'b1 : held_waiter_base;

  logic caller_wr, wake_wr;
  assign caller_wr  = (state_r == mtwq_pkg::S_READ) && (do_grant || do_unlock) && t_ok;
  assign wake_wr    = (state_r == mtwq_pkg::S_WAKE) && wv_r && (wt_r != tid_r);
  assign held_we    = caller_wr || wake_wr;
  assign held_waddr = wake_wr ? wt_r[TIW-1:0] : ti;
  assign held_wdata = wake_wr ? held_waiter_inc : held_caller;
  assign held_raddr = (state_r == mtwq_pkg::S_READ) ? w_c[TIW-1:0]
                                                    : in_ch.task_id[TIW-1:0];

  assign nw_we    = (state_r == mtwq_pkg::S_READ) && do_enq && q_ne_r[mi];
  assign nw_waddr = q_tail_r[mi][TIW-1:0];
  assign nw_wdata = tid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtwq_pkg::S_IDLE: if (accept) state_nxt = mtwq_pkg::S_READ;
      mtwq_pkg::S_READ: state_nxt = mtwq_pkg::S_WAKE;
      mtwq_pkg::S_WAKE: state_nxt = mtwq_pkg::S_OUT;
      mtwq_pkg::S_OUT:  if (out_ch.ready) state_nxt = mtwq_pkg::S_IDLE;
      default:          state_nxt = mtwq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtwq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.command;
      mid_r <= in_ch.mutex_id;
      tid_r <= in_ch.task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mtwq_pkg::S_READ) begin
      status_r   <= st_c;
      newm_r     <= do_create ? mtwq_pkg::NEWM_W'(free_idx) : '0;
      sleep_r    <= sleep_c;
      wv_r       <= wv_c;
      wt_r       <= wt_c;
      held_out_r <= (do_release || !t_ok) ? '0 : held_caller;
    end
  end

  // Count valid bits: set on every count write, cleared by reset and release-all.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= '0;
    end else if (state_r == mtwq_pkg::S_READ && do_release) begin
      held_vld_r <= '0;
    end else if (held_we) begin
      held_vld_r[held_waddr] <= 1'b1;
    end
  end

  // Table updates, applied in the compute cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      own_v_r <= '0;
      q_ne_r  <= '0;
      for (int i = 0; i < MUTEX_COUNT; i++) begin
        own_t_r[i]  <= '0;
        q_head_r[i] <= '0;
        q_tail_r[i] <= '0;
      end
    end else if (state_r == mtwq_pkg::S_READ) begin
      if (do_create) begin
        alloc_r[free_idx] <= 1'b1;
      end
      if (do_release) begin
        own_v_r <= '0;
        q_ne_r  <= '0;
      end
      if (do_grant) begin
        own_v_r[mi] <= 1'b1;
        own_t_r[mi] <= tid_r;
      end
      if (do_enq) begin
        if (!q_ne_r[mi]) begin
          q_head_r[mi] <= tid_r;
          q_ne_r[mi]   <= 1'b1;
        end
        q_tail_r[mi] <= tid_r;
      end
      if (do_unlock) begin
        if (do_handoff) begin
          if (w_c == q_tail_r[mi]) begin
            q_ne_r[mi] <= 1'b0;
          end else begin
            q_head_r[mi] <= nw_rdata;
          end
          own_t_r[mi] <= w_c;
        end else begin
          own_v_r[mi] <= 1'b0;
        end
      end
    end
  end

endmodule

@@ tb/mtwq_checker.sv @@
`timescale 1ns / 1ps

module mtwq_checker
  import mtwq_pkg::*;
#(
  parameter int MUTEX_COUNT = MUTEX_COUNT_DEF,
  parameter int TASK_COUNT  = TASK_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mtwq_in_if   in_mon,
  mtwq_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    status_t            status;
    logic [NEWM_W-1:0]  new_mutex;
    logic               must_sleep;
    logic               wake_valid;
    logic [TASK_W-1:0]  wake_task;
    logic [HELD_W-1:0]  caller_held;
  } lock_reply_t;

  // Shadow of the mutex table, the wait queues and the per-task counts.
  logic              allocated      [64];
  logic              owner_valid    [64];
  logic [TASK_W-1:0] owner_task     [64];
  logic              queue_nonempty [64];
  logic [TASK_W-1:0] queue_head     [64];
  logic [TASK_W-1:0] queue_tail     [64];
  logic [TASK_W-1:0] next_waiter    [64];
  logic [HELD_W-1:0] held_count     [64];

  lock_reply_t replies_due[$];

  function automatic lock_reply_t apply_command(cmd_t c, logic [ID_W-1:0] m,
                                                logic [TASK_W-1:0] t);
    lock_reply_t r;
    logic found;
    logic [TASK_W-1:0] w;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    case (c)
      CMD_CREATE: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < MUTEX_COUNT; i++) begin
          if (!found && !allocated[i]) begin
            allocated[i] = 1'b1;
            r.new_mutex = i[NEWM_W-1:0];
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < 64; i++) begin
          owner_valid[i] = 1'b0;
          queue_nonempty[i] = 1'b0;
          held_count[i] = '0;
        end
      end
      default: begin
        if (m >= MUTEX_COUNT || !allocated[m] || t >= TASK_COUNT) begin
          r.status = ST_INVALID;
        end else if (c == CMD_LOCK) begin
          if (owner_valid[m] && owner_task[m] == t) begin
            r.status = ST_DEADLOCK;
          end else if (owner_valid[m]) begin
            if (queue_nonempty[m]) begin
              next_waiter[queue_tail[m]] = t;
            end else begin
              queue_head[m] = t;
              queue_nonempty[m] = 1'b1;
            end
            queue_tail[m] = t;
            r.must_sleep = 1'b1;
          end else begin
            owner_valid[m] = 1'b1;
            owner_task[m] = t;
            if (held_count[t] < 63) held_count[t]++;
          end
        end else begin
          if (!owner_valid[m] || owner_task[m] != t) begin
            r.status = ST_NOT_OWNER;
          end else begin
            if (held_count[t] > 0) held_count[t]--;
            if (queue_nonempty[m]) begin
              // Direct handoff: the head waiter becomes the owner at once.
              w = queue_head[m];
              if (w == queue_tail[m]) queue_nonempty[m] = 1'b0;
              else queue_head[m] = next_waiter[w];
              owner_task[m] = w;
              if (held_count[w] < 63) held_count[w]++;
              r.wake_valid = 1'b1;
              r.wake_task = w;
            end else begin
              owner_valid[m] = 1'b0;
            end
          end
        end
      end
    endcase
    r.caller_held = (t < TASK_COUNT) ? held_count[t] : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    lock_reply_t want;
    lock_reply_t got;
    if (!rst_n) begin
      for (int i = 0; i < 64; i++) begin
        allocated[i] = 1'b0;
        owner_valid[i] = 1'b0;
        owner_task[i] = '0;
        queue_nonempty[i] = 1'b0;
        queue_head[i] = '0;
        queue_tail[i] = '0;
        next_waiter[i] = '0;
        held_count[i] = '0;
      end
      replies_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.status      = status_t'(out_mon.status);
        got.new_mutex   = out_mon.new_mutex;
        got.must_sleep  = out_mon.must_sleep;
        got.wake_valid  = out_mon.wake_valid;
        got.wake_task   = out_mon.wake_task;
        got.caller_held = out_mon.caller_held;
        if (replies_due.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result transaction: status=%0d", got.status);
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: expected st=%0d nm=%0d sl=%0b wv=%0b wt=%0d held=%0d",
                        " got st=%0d nm=%0d sl=%0b wv=%0b wt=%0d held=%0d"},
                       want.status, want.new_mutex, want.must_sleep, want.wake_valid,
                       want.wake_task, want.caller_held, got.status, got.new_mutex,
                       got.must_sleep, got.wake_valid, got.wake_task, got.caller_held);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        replies_due.push_back(apply_command(cmd_t'(in_mon.command), in_mon.mutex_id,
                                            in_mon.task_id));
      pending <= replies_due.size();
    end
  end

endmodule

@@ tb/tb_mutex_table_with_wait_queues_unit.sv @@
`timescale 1ns / 1ps

module tb_mutex_table_with_wait_queues_unit;
  import mtwq_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;

  mtwq_in_if  in_ch();
  mtwq_out_if out_ch();

  mutex_table_with_wait_queues_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // The checker watches both channels, predicts every reply and counts failures.
  mtwq_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The result side stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a long stretch without any transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
        $display("mutex_table_with_wait_queues_unit regression: fail");
        $finish;
      end
    end
  end

  // Presents one command, after a random idle gap, and holds it until accepted.
  // Valid is written once per edge, so back-to-back commands keep it high.
  task automatic issue(cmd_t c, int m, int t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= c;
    in_ch.mutex_id <= m[ID_W-1:0];
    in_ch.task_id  <= t[TASK_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random traffic: mostly contention among a few tasks on a few mutexes so that
  // queues grow and handoffs happen, plus wide ids and occasional global release.
  task automatic random_traffic(int n);
    int pick;
    int m;
    int t;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        m = $urandom_range(63);
        t = $urandom_range(63);
      end else begin
        m = $urandom_range(3);
        t = $urandom_range(3);
      end
      if (pick < 3)       issue(CMD_CREATE, $urandom_range(63), t);
      else if (pick < 5)  issue(CMD_RELEASE, $urandom_range(63), $urandom_range(63));
      else if (pick < 55) issue(CMD_LOCK, m, t);
      else                issue(CMD_UNLOCK, m, t);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_CREATE;
    in_ch.mutex_id = '0;
    in_ch.task_id  = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 24;
    recv_idle_pct  = 56;
    quiet_cycles   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every next-waiter link is written once before anything else, so a later
    // handoff can never follow a link that holds no defined value.
    issue(CMD_CREATE, 0, 0);
    issue(CMD_LOCK, 0, 0);
    for (int t = 1; t < 64; t++) issue(CMD_LOCK, 0, t);
    issue(CMD_LOCK, 0, 1);
    issue(CMD_CREATE, 0, 0);
    issue(CMD_LOCK, 1, 1);
    issue(CMD_LOCK, 1, 0);
    issue(CMD_LOCK, 1, 2);
    issue(CMD_RELEASE, 0, 0);

    // Directed cases: invalid ids, self lock, wrong owner, queued waiters with
    // handoff in order, release of a free mutex and a full table.
    issue(CMD_LOCK, 63, 5);
    issue(CMD_LOCK, 32, 5);
    issue(CMD_UNLOCK, 7, 5);
    issue(CMD_LOCK, 0, 63);
    issue(CMD_LOCK, 0, 63);
    issue(CMD_UNLOCK, 0, 5);
    issue(CMD_LOCK, 0, 5);
    issue(CMD_LOCK, 0, 0);
    issue(CMD_LOCK, 0, 5);
    issue(CMD_UNLOCK, 0, 63);
    issue(CMD_UNLOCK, 0, 5);
    issue(CMD_UNLOCK, 0, 0);
    issue(CMD_UNLOCK, 0, 5);
    issue(CMD_UNLOCK, 0, 5);
    for (int k = 0; k < 31; k++) issue(CMD_CREATE, 63, 63);
    issue(CMD_LOCK, 31, 42);
    issue(CMD_RELEASE, 63, 63);
    drain();

    random_traffic(410);
    drain();
    send_idle_pct = 56;
    recv_idle_pct = 24;
    random_traffic(410);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(410);
    drain();
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("mutex_table_with_wait_queues_unit regression: pass");
    end else begin
      $display("mutex_table_with_wait_queues_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/mtwq_pkg.sv
rtl/mtwq_if.sv
rtl/mtwq_ram.sv
rtl/mutex_table_with_wait_queues_unit.sv
tb/mtwq_checker.sv
tb/tb_mutex_table_with_wait_queues_unit.sv
